>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lfu_pkg.sv
// Types and constants for the LFU cache
package lfu_pkg;

  localparam int IDX_MAX_W = 8;
  localparam int CNT_MAX_W = 32;
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Partial search result passed from cell to cell
  typedef struct packed {
    logic                 found;
    logic [DATA_W-1:0]    f_data;
    logic [IDX_MAX_W-1:0] f_idx;
    logic [IDX_MAX_W-1:0] f_rank;
    logic                 has_v;
    logic [CNT_MAX_W-1:0] v_cnt;
    logic [IDX_MAX_W-1:0] v_rank;
    logic [KEY_W-1:0]     v_key;
    logic [IDX_MAX_W-1:0] v_idx;
    logic                 has_free;
    logic [IDX_MAX_W-1:0] free_idx;
  } wave_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic                 en;
    logic                 is_hit;
    logic                 is_put;
    logic [IDX_MAX_W-1:0] tgt_idx;
    logic [IDX_MAX_W-1:0] tgt_rank;
    logic                 evict;
    logic [IDX_MAX_W-1:0] v_idx;
    logic [IDX_MAX_W-1:0] v_rank;
    logic [IDX_MAX_W-1:0] slot_idx;
    logic [KEY_W-1:0]     key;
    logic [DATA_W-1:0]    value;
  } cmd_t;

endpackage

>>> hdl/lfu_cell.sv
// One cache entry: key match, victim and free-slot search stage, local update
module lfu_cell #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16,
  parameter int IDX        = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lfu_pkg::KEY_W-1:0]  key_i,
  input  lfu_pkg::wave_t             wave_i,
  output lfu_pkg::wave_t             wave_o,
  input  lfu_pkg::cmd_t              cmd_i
);
  import lfu_pkg::*;

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_MAX_W-1:0] ME = IDX_MAX_W'(IDX);

  logic                  valid_r, valid_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [DATA_W-1:0]     data_r, data_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0]         rank_r, rank_nxt;
  wave_t                 wave_r, wave_nxt;

  logic [IDX_MAX_W-1:0] rank_x;
  logic [CNT_MAX_W-1:0] cnt_x;

  assign rank_x = IDX_MAX_W'(rank_r);
  assign cnt_x  = CNT_MAX_W'(cnt_r);

  always_comb begin
    wave_nxt = wave_i;
    if (valid_r && key_r == key_i && !wave_i.found) begin
      wave_nxt.found  = 1'b1;
      wave_nxt.f_data = data_r;
      wave_nxt.f_idx  = ME;
      wave_nxt.f_rank = rank_x;
    end
    // ranks of valid entries are distinct, so the minimum is unique
    if (valid_r && (!wave_i.has_v || cnt_x < wave_i.v_cnt ||
        (cnt_x == wave_i.v_cnt && rank_x > wave_i.v_rank))) begin
      wave_nxt.has_v  = 1'b1;
      wave_nxt.v_cnt  = cnt_x;
      wave_nxt.v_rank = rank_x;
      wave_nxt.v_key  = key_r;
      wave_nxt.v_idx  = ME;
    end
    if (!valid_r && !wave_i.has_free) begin
      wave_nxt.has_free = 1'b1;
      wave_nxt.free_idx = ME;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    data_nxt  = data_r;
    cnt_nxt   = cnt_r;
    rank_nxt  = rank_r;
    if (cmd_i.en) begin
      if (cmd_i.is_hit) begin
        if (cmd_i.tgt_idx == ME) begin
          rank_nxt = '0;
          if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
          if (cmd_i.is_put) data_nxt = cmd_i.value;
        end else if (valid_r && rank_x < cmd_i.tgt_rank) begin
          rank_nxt = rank_r + 1'b1;
        end
      end else if (cmd_i.slot_idx == ME) begin
        valid_nxt = 1'b1;
        key_nxt   = cmd_i.key;
        data_nxt  = cmd_i.value;
        cnt_nxt   = COUNT_BITS'(1);
        rank_nxt  = '0;
      end else if (cmd_i.evict && cmd_i.v_idx == ME) begin
        valid_nxt = 1'b0;
      end else if (valid_r && !(cmd_i.evict && rank_x > cmd_i.v_rank)) begin
        // entries older than the victim age once and shift back once
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    key_r  <= key_nxt;
    data_r <= data_nxt;
    cnt_r  <= cnt_nxt;
    rank_r <= rank_nxt;
    wave_r <= wave_nxt;
  end

  assign wave_o = wave_r;

endmodule

>>> hdl/lfu_cache_lru_tiebreak_core.sv
// LFU cache with LRU tie-break, top level: control, occupancy, result register.
// A request is accepted in S_IDLE, searched in S_SCAN, applied in S_UPD, then the out_valid strobe is registered.
// A new request is taken only when idle; the search ripples one cell per cycle.
// busy is high from accept until the result strobe; the receiver cannot stall.
// Synchronous active-low reset clears all valid bits, occupancy and control;
// capacity resets to 16.
`include "assert_macros.svh"
module lfu_cache_lru_tiebreak_core #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_func,
  input  logic [lfu_pkg::KEY_W-1:0]    in_key,
  input  logic [lfu_pkg::DATA_W-1:0]   in_value,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [lfu_pkg::DATA_W-1:0]   out_data,
  output logic                         out_evicted,
  output logic [lfu_pkg::KEY_W-1:0]    out_evicted_key,
  input  logic                         cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]    cfg_wdata
);
  import lfu_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} state_t;

  state_t            state_r;
  logic [IW-1:0]     cnt_r;
  logic              func_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] value_r;
  logic [CAP_W-1:0]  capacity_r;
  logic [OW-1:0]     occ_r, occ_nxt;
  logic              out_valid_r, out_hit_r, out_evicted_r;
  logic [DATA_W-1:0] out_data_r;
  logic [KEY_W-1:0]  out_evicted_key_r;

  wave_t wave [ENTRIES+1];
  wave_t last;
  cmd_t  cmd;
  logic  evict;
  logic [8:0] cap_eff;

  assign wave[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS), .IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .key_i  (key_r),
      .wave_i (wave[i]),
      .wave_o (wave[i+1]),
      .cmd_i  (cmd)
    );
  end

  assign last = wave[ENTRIES];

  always_comb begin
    if (capacity_r == '0)                   cap_eff = 9'd1;
    else if (9'(capacity_r) > 9'(ENTRIES))  cap_eff = 9'(ENTRIES);
    else                                    cap_eff = 9'(capacity_r);
  end

  assign evict = !last.found && func_r && (9'(occ_r) >= cap_eff);

  always_comb begin
    cmd          = '0;
    cmd.en       = (state_r == S_UPD);
    cmd.is_hit   = last.found;
    cmd.is_put   = func_r;
    cmd.tgt_idx  = last.f_idx;
    cmd.tgt_rank = last.f_rank;
    cmd.evict    = evict;
    cmd.v_idx    = last.v_idx;
    cmd.v_rank   = last.v_rank;
    cmd.key      = key_r;
    cmd.value    = value_r;
    // lowest free cell once the victim is gone
    if (evict && !(last.has_free && last.free_idx < last.v_idx)) cmd.slot_idx = last.v_idx;
    else                                                      cmd.slot_idx = last.free_idx;
    // a get miss touches nothing
    if (!last.found && !func_r) cmd.en = 1'b0;
  end

  always_comb begin
    occ_nxt = occ_r;
    if (state_r == S_UPD && !last.found && func_r && !evict) occ_nxt = occ_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      capacity_r  <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) capacity_r <= cfg_wdata;
      occ_r       <= occ_nxt;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_SCAN;
            cnt_r   <= '0;
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IW'(ENTRIES - 1)) state_r <= S_UPD;
        end
        S_UPD: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (state_r == S_IDLE && start) begin
      func_r  <= in_func;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (state_r == S_UPD) begin
      out_hit_r         <= last.found;
      out_data_r        <= (last.found && !func_r) ? last.f_data : '0;
      out_evicted_r     <= evict;
      out_evicted_key_r <= evict ? last.v_key : '0;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_data        = out_data_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not raise busy")
  `CHK_NOW(a_strobe_after_busy, clk, rst_n, out_valid, $past(busy) && !busy, "stray result strobe")
  `CHK_NOW(a_evict_not_hit, clk, rst_n, out_valid && out_evicted, !out_hit, "eviction on a hit")
  `CHK_NOW(a_occ_bound, clk, rst_n, 1'b1, 9'(occ_r) <= 9'(ENTRIES), "occupancy beyond entries")

endmodule
